// ===== src/glxy_pkg.sv =====
package glxy_pkg;

  localparam int unsigned DIV_STEPS = 62;
  localparam int unsigned LAST_STG  = 74;

  localparam logic signed [63:0] CDEG = 64'sd491266511;
  localparam logic signed [63:0] KINV = 64'sd615208748018788;
  localparam logic [63:0]        SATMAG = 64'h2000_0000_0000_0000;

  localparam logic signed [31:0] LAT_LIM = 32'sd900000000;
  localparam logic signed [31:0] LON_LIM = 32'sd1800000000;

  localparam logic signed [63:0] XY_MAX64  = 64'sd1099511627775;
  localparam logic signed [63:0] XY_MIN64  = -64'sd1099511627776;
  localparam logic signed [63:0] I32_MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] I32_MIN64 = -64'sd2147483648;

  typedef enum logic [2:0] {
    CFG_REF_LAT    = 3'd0,
    CFG_REF_LON    = 3'd1,
    CFG_NORTH_RAD  = 3'd2,
    CFG_EAST_RAD   = 3'd3,
    CFG_HEAD_COS   = 3'd4,
    CFG_HEAD_SIN   = 3'd5,
    CFG_ORIGIN_SET = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic v;
    logic func;
    logic ok;
  } side_t;

  typedef struct packed {
    logic signed [40:0] x;
    logic signed [40:0] y;
  } xy_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // round half away from zero, shift, saturate magnitude, apply sign
  function automatic logic signed [63:0] rsat(input logic [127:0] p, input logic [6:0] sh,
                                              input logic neg);
    logic [127:0] m;
    logic [63:0]  r;
    m = (p + (128'd1 << (sh - 7'd1))) >> sh;
    r = (m > {64'd0, SATMAG}) ? SATMAG : m[63:0];
    return neg ? $signed(-r) : $signed(r);
  endfunction

  function automatic logic signed [40:0] rnd8_sat41(input logic signed [63:0] v);
    logic [63:0]        m;
    logic signed [63:0] s;
    m = (mag64(v) + 64'd128) >> 8;
    s = v[63] ? -$signed(m) : $signed(m);
    if (s > XY_MAX64) begin
      s = XY_MAX64;
    end else if (s < XY_MIN64) begin
      s = XY_MIN64;
    end
    return s[40:0];
  endfunction

  function automatic logic signed [31:0] fin32(input logic [DIV_STEPS-1:0] q, input logic ovf,
                                               input logic neg, input logic signed [31:0] base);
    logic [63:0]        m;
    logic signed [63:0] s;
    m = (ovf || ({{(64-DIV_STEPS){1'b0}}, q} > SATMAG)) ? SATMAG
                                                        : {{(64-DIV_STEPS){1'b0}}, q};
    s = (neg ? -$signed(m) : $signed(m)) + {{32{base[31]}}, base};
    if (s > I32_MAX64) begin
      s = I32_MAX64;
    end else if (s < I32_MIN64) begin
      s = I32_MIN64;
    end
    return s[31:0];
  endfunction

endpackage

// ===== src/geodetic_local_xy_converter_core.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_stall    in_func, in_latitude_in, in_longitude_in, in_x_in, in_y_in
// result    out_valid / out_stall  out_ok, out_x_out, out_y_out, out_latitude_out,
//                                  out_longitude_out
// config    cfg_we                 cfg_index, cfg_wdata
//
// One transaction per cycle while the pipeline advances; the result passes through the multiply stages
// and the 63-stage pipelined divider of the inverse direction before the output register.
// The whole pipeline advances unless the output holds a result and out_stall is high.
// rst_n is synchronous; it clears valid bits and configuration, but sets the heading cosine to 1073741824.
module geodetic_local_xy_converter_core import glxy_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic signed [31:0] in_latitude_in,
  input  logic signed [31:0] in_longitude_in,
  input  logic signed [40:0] in_x_in,
  input  logic signed [40:0] in_y_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic signed [40:0] out_x_out,
  output logic signed [40:0] out_y_out,
  output logic signed [31:0] out_latitude_out,
  output logic signed [31:0] out_longitude_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  // configuration
  logic signed [30:0] ref_lat_r;
  logic signed [31:0] ref_lon_r;
  logic [31:0]        north_r;
  logic [31:0]        east_r;
  logic signed [31:0] cos_r;
  logic signed [31:0] sin_r;
  logic               origin_r;
  logic [63:0]        den_lat_r;
  logic [63:0]        den_lon;
  logic [31:0]        cos_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r <= '0;
      ref_lon_r <= '0;
      north_r   <= '0;
      east_r    <= '0;
      cos_r     <= 32'sd1073741824;
      sin_r     <= '0;
      origin_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REF_LAT:    ref_lat_r <= cfg_wdata[30:0];
        CFG_REF_LON:    ref_lon_r <= cfg_wdata;
        CFG_NORTH_RAD:  north_r   <= cfg_wdata;
        CFG_EAST_RAD:   east_r    <= cfg_wdata;
        CFG_HEAD_COS:   cos_r     <= cfg_wdata;
        CFG_HEAD_SIN:   sin_r     <= cfg_wdata;
        CFG_ORIGIN_SET: origin_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cos_mag = cos_r[31] ? 32'(-cos_r) : 32'(cos_r);
  assign den_lon = {2'b00, east_r, 30'd0};

  always_ff @(posedge clk) begin
    den_lat_r <= {32'd0, cos_mag} * {32'd0, north_r};
  end

  logic signed [63:0] north64;
  logic signed [63:0] east64;
  logic signed [63:0] cos64;
  logic signed [63:0] sin64;
  assign north64 = $signed({32'd0, north_r});
  assign east64  = $signed({32'd0, east_r});
  assign cos64   = {{32{cos_r[31]}}, cos_r};
  assign sin64   = {{32{sin_r[31]}}, sin_r};

  // flow control
  logic adv;
  logic out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  side_t side_r [0:LAST_STG];

  // stage 0
  logic signed [31:0] lat0_r;
  logic signed [31:0] lon0_r;
  logic signed [40:0] x0_r;
  logic signed [40:0] y0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      lat0_r <= in_latitude_in;
      lon0_r <= in_longitude_in;
      x0_r   <= in_x_in;
      y0_r   <= in_y_in;
    end
  end

  // stage 1
  logic               ok1;
  logic signed [33:0] dlat;
  logic signed [33:0] dlon;
  logic signed [63:0] tlat1_r;
  logic signed [63:0] tlon1_r;

  always_comb begin
    if (!side_r[0].func) begin
      ok1 = origin_r && (lat0_r >= -LAT_LIM) && (lat0_r <= LAT_LIM)
            && (lon0_r >= -LON_LIM) && (lon0_r <= LON_LIM);
    end else begin
      ok1 = origin_r && (cos_r != '0) && (north_r != '0) && (east_r != '0);
    end
  end

  assign dlat = {{2{lat0_r[31]}}, lat0_r} - {{3{ref_lat_r[30]}}, ref_lat_r};
  assign dlon = {{2{lon0_r[31]}}, lon0_r} - {{2{ref_lon_r[31]}}, ref_lon_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      tlat1_r <= $signed({{30{dlat[33]}}, dlat}) * CDEG;
      tlon1_r <= $signed({{30{dlon[33]}}, dlon}) * CDEG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAST_STG; k++) begin
        side_r[k] <= '0;
      end
    end else if (adv) begin
      side_r[0] <= '{v: in_valid, func: in_func, ok: 1'b0};
      side_r[1] <= '{v: side_r[0].v, func: side_r[0].func, ok: ok1};
      for (int k = 2; k <= LAST_STG; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // forward: radii scaling (stages 2..4)
  logic [127:0]       p_dn;
  logic [127:0]       p_de;
  logic               n_dn;
  logic               n_de;
  logic signed [63:0] dn4_r;
  logic signed [63:0] de4_r;

  glxy_mul u_mul_dn (.clk, .en(adv), .a(tlat1_r), .b(north64), .p(p_dn), .neg(n_dn));
  glxy_mul u_mul_de (.clk, .en(adv), .a(tlon1_r), .b(east64),  .p(p_de), .neg(n_de));

  always_ff @(posedge clk) begin
    if (adv) begin
      dn4_r <= rsat(p_dn, 7'd48, n_dn);
      de4_r <= rsat(p_de, 7'd48, n_de);
    end
  end

  // forward: rotation (stages 5..8)
  logic [127:0]       p_yc;
  logic [127:0]       p_ys;
  logic [127:0]       p_xc;
  logic [127:0]       p_xs;
  logic               n_yc;
  logic               n_ys;
  logic               n_xc;
  logic               n_xs;
  logic signed [63:0] yc7_r;
  logic signed [63:0] ys7_r;
  logic signed [63:0] xc7_r;
  logic signed [63:0] xs7_r;
  xy_t                fxy_r [8:LAST_STG];

  glxy_mul u_mul_yc (.clk, .en(adv), .a(dn4_r), .b(cos64), .p(p_yc), .neg(n_yc));
  glxy_mul u_mul_ys (.clk, .en(adv), .a(de4_r), .b(sin64), .p(p_ys), .neg(n_ys));
  glxy_mul u_mul_xc (.clk, .en(adv), .a(de4_r), .b(cos64), .p(p_xc), .neg(n_xc));
  glxy_mul u_mul_xs (.clk, .en(adv), .a(dn4_r), .b(sin64), .p(p_xs), .neg(n_xs));

  always_ff @(posedge clk) begin
    if (adv) begin
      yc7_r <= rsat(p_yc, 7'd30, n_yc);
      ys7_r <= rsat(p_ys, 7'd30, n_ys);
      xc7_r <= rsat(p_xc, 7'd30, n_xc);
      xs7_r <= rsat(p_xs, 7'd30, n_xs);
      fxy_r[8] <= '{x: rnd8_sat41(xc7_r - xs7_r), y: rnd8_sat41(yc7_r + ys7_r)};
      for (int k = 9; k <= LAST_STG; k++) begin
        fxy_r[k] <= fxy_r[k-1];
      end
    end
  end

  // inverse: unrotate (stages 1..8)
  logic [127:0]       p_xci;
  logic [127:0]       p_ysi;
  logic [127:0]       p_ds;
  logic               n_xci;
  logic               n_ysi;
  logic               n_ds;
  logic signed [63:0] xci3_r;
  logic signed [63:0] ysi3_r;
  logic signed [63:0] dei4_r;
  logic signed [63:0] ds7_r;
  logic signed [63:0] de_r  [5:8];
  logic signed [40:0] yv_r  [1:7];
  logic signed [63:0] num8_r;

  glxy_mul u_mul_xci (.clk, .en(adv), .a({{23{x0_r[40]}}, x0_r}), .b(cos64),
                      .p(p_xci), .neg(n_xci));
  glxy_mul u_mul_ysi (.clk, .en(adv), .a({{23{y0_r[40]}}, y0_r}), .b(sin64),
                      .p(p_ysi), .neg(n_ysi));
  glxy_mul u_mul_ds  (.clk, .en(adv), .a(dei4_r), .b(sin64), .p(p_ds), .neg(n_ds));

  always_ff @(posedge clk) begin
    if (adv) begin
      xci3_r <= rsat(p_xci, 7'd22, n_xci);
      ysi3_r <= rsat(p_ysi, 7'd22, n_ysi);
      dei4_r <= xci3_r + ysi3_r;
      de_r[5] <= dei4_r;
      for (int k = 6; k <= 8; k++) begin
        de_r[k] <= de_r[k-1];
      end
      yv_r[1] <= y0_r;
      for (int k = 2; k <= 7; k++) begin
        yv_r[k] <= yv_r[k-1];
      end
      ds7_r  <= rsat(p_ds, 7'd30, n_ds);
      num8_r <= $signed({{15{yv_r[7][40]}}, yv_r[7], 8'd0}) - ds7_r;
    end
  end

  // inverse: scale by KINV and add half divisor (stages 9..11)
  logic [127:0] p_kl;
  logic [127:0] p_ko;
  logic         n_kl;
  logic         n_ko;
  logic [127:0] nlat11_r;
  logic [127:0] nlon11_r;
  logic         neglat11_r;
  logic         neglon11_r;

  glxy_mul u_mul_kl (.clk, .en(adv), .a(num8_r),  .b(KINV), .p(p_kl), .neg(n_kl));
  glxy_mul u_mul_ko (.clk, .en(adv), .a(de_r[8]), .b(KINV), .p(p_ko), .neg(n_ko));

  always_ff @(posedge clk) begin
    if (adv) begin
      nlat11_r   <= p_kl + {65'd0, den_lat_r[63:1]};
      nlon11_r   <= p_ko + {65'd0, den_lon[63:1]};
      neglat11_r <= n_kl ^ cos_r[31];
      neglon11_r <= n_ko;
    end
  end

  // inverse: dividers (stages 12..74)
  logic [DIV_STEPS-1:0] q_lat;
  logic [DIV_STEPS-1:0] q_lon;
  logic                 ovf_lat;
  logic                 ovf_lon;
  logic                 neg_lat;
  logic                 neg_lon;

  glxy_div u_div_lat (.clk, .en(adv), .n(nlat11_r), .den(den_lat_r), .neg(neglat11_r),
                      .q(q_lat), .ovf(ovf_lat), .neg_o(neg_lat));
  glxy_div u_div_lon (.clk, .en(adv), .n(nlon11_r), .den(den_lon), .neg(neglon11_r),
                      .q(q_lon), .ovf(ovf_lon), .neg_o(neg_lon));

  // output register
  side_t              sfin;
  logic signed [31:0] lat_fin;
  logic signed [31:0] lon_fin;
  logic               ok_r;
  logic signed [40:0] x_r;
  logic signed [40:0] y_r;
  logic signed [31:0] lat_r;
  logic signed [31:0] lon_r;

  assign sfin    = side_r[LAST_STG];
  assign lat_fin = fin32(q_lat, ovf_lat, neg_lat, {ref_lat_r[30], ref_lat_r});
  assign lon_fin = fin32(q_lon, ovf_lon, neg_lon, ref_lon_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sfin.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok_r  <= sfin.ok;
      x_r   <= (sfin.ok && !sfin.func) ? fxy_r[LAST_STG].x : '0;
      y_r   <= (sfin.ok && !sfin.func) ? fxy_r[LAST_STG].y : '0;
      lat_r <= (sfin.ok && sfin.func) ? lat_fin : '0;
      lon_r <= (sfin.ok && sfin.func) ? lon_fin : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = ok_r;
  assign out_x_out         = x_r;
  assign out_y_out         = y_r;
  assign out_latitude_out  = lat_r;
  assign out_longitude_out = lon_r;

endmodule

// ===== src/glxy_mul.sv =====
module glxy_mul import glxy_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic [127:0]       p,
  output logic               neg
);

  logic [63:0]  am;
  logic [63:0]  bm;
  logic [63:0]  pp00_r;
  logic [63:0]  pp01_r;
  logic [63:0]  pp10_r;
  logic [63:0]  pp11_r;
  logic         neg1_r;
  logic [127:0] p_r;
  logic         neg2_r;

  assign am = mag64(a);
  assign bm = mag64(b);

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= 64'(am[31:0])  * 64'(bm[31:0]);
      pp01_r <= 64'(am[31:0])  * 64'(bm[63:32]);
      pp10_r <= 64'(am[63:32]) * 64'(bm[31:0]);
      pp11_r <= 64'(am[63:32]) * 64'(bm[63:32]);
      neg1_r <= a[63] ^ b[63];
      p_r    <= {64'd0, pp00_r} + {32'd0, pp01_r, 32'd0} + {32'd0, pp10_r, 32'd0}
              + {pp11_r, 64'd0};
      neg2_r <= neg1_r;
    end
  end

  assign p   = p_r;
  assign neg = neg2_r;

endmodule

// ===== src/glxy_div.sv =====
module glxy_div import glxy_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [127:0]         n,
  input  logic [63:0]          den,
  input  logic                 neg,
  output logic [DIV_STEPS-1:0] q,
  output logic                 ovf,
  output logic                 neg_o
);

  logic [63:0]          r_r   [0:DIV_STEPS-1];
  logic [DIV_STEPS-1:0] nl_r  [0:DIV_STEPS-1];
  logic [DIV_STEPS-1:0] q_r   [0:DIV_STEPS];
  logic                 ovf_r [0:DIV_STEPS];
  logic                 neg_r [0:DIV_STEPS];
  logic [64:0]          r2    [0:DIV_STEPS-1];
  logic                 ge    [0:DIV_STEPS-1];
  logic [63:0]          rn    [0:DIV_STEPS-1];

  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      r2[j] = {r_r[j], nl_r[j][DIV_STEPS-1]};
      ge[j] = r2[j] >= {1'b0, den};
      rn[j] = ge[j] ? 64'(r2[j] - {1'b0, den}) : r2[j][63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= n[127:DIV_STEPS] >= {{(64-DIV_STEPS){1'b0}}, den};
      r_r[0]   <= n[DIV_STEPS+63:DIV_STEPS];
      nl_r[0]  <= n[DIV_STEPS-1:0];
      q_r[0]   <= '0;
      neg_r[0] <= neg;
      for (int j = 1; j < DIV_STEPS; j++) begin
        r_r[j]  <= rn[j-1];
        nl_r[j] <= {nl_r[j-1][DIV_STEPS-2:0], 1'b0};
      end
      for (int j = 1; j <= DIV_STEPS; j++) begin
        q_r[j]   <= {q_r[j-1][DIV_STEPS-2:0], ge[j-1]};
        ovf_r[j] <= ovf_r[j-1];
        neg_r[j] <= neg_r[j-1];
      end
    end
  end

  assign q     = q_r[DIV_STEPS];
  assign ovf   = ovf_r[DIV_STEPS];
  assign neg_o = neg_r[DIV_STEPS];

endmodule

// ===== src/glxy_chk.sv =====
module glxy_chk import glxy_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_ok,
  input logic signed [40:0] out_x_out,
  input logic signed [40:0] out_y_out,
  input logic signed [31:0] out_latitude_out,
  input logic signed [31:0] out_longitude_out
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x_out) && $stable(out_y_out)
      && $stable(out_latitude_out) && $stable(out_longitude_out) && $stable(out_ok))
    else $error("stalled transaction changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_x_out == '0 && out_y_out == '0
      && out_latitude_out == '0 && out_longitude_out == '0)
    else $error("failed conversion carries nonzero fields");

  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_x_out != '0 || out_y_out != '0)
      |-> out_latitude_out == '0 && out_longitude_out == '0)
    else $error("both directions populated");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

endmodule

bind geodetic_local_xy_converter_core glxy_chk u_glxy_chk (.*);
